### hdl/kiac_pkg.sv
`timescale 1ns / 1ps

package kiac_pkg;

  // Counter and register width; every timing register and tick counter uses it.
  localparam int TIMER_BITS = 16;
  localparam int SEQ_LEN    = 3;
  localparam int CFG_IDX_W  = 3;

  typedef logic [TIMER_BITS-1:0] tmr_t;

  // Internal operating mode, one-hot.
  typedef enum logic [3:0] {
    MODE_DISARMED = 4'b0001,
    MODE_EXIT     = 4'b0010,
    MODE_ARMED    = 4'b0100,
    MODE_ALARM    = 4'b1000
  } mode_t;

  // Encoded mode as seen on the result channel.
  localparam logic [1:0] MODE_CODE_DISARMED = 2'd0;
  localparam logic [1:0] MODE_CODE_EXIT     = 2'd1;
  localparam logic [1:0] MODE_CODE_ARMED    = 2'd2;
  localparam logic [1:0] MODE_CODE_ALARM    = 2'd3;

  localparam logic [1:0] REMOTE_ARM    = 2'd1;
  localparam logic [1:0] REMOTE_DISARM = 2'd2;

  localparam logic [1:0] KEY_ONE   = 2'd1;
  localparam logic [1:0] KEY_TWO   = 2'd2;
  localparam logic [1:0] KEY_THREE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_DELAY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_TIMEOUT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIREN_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIREN_BEEP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SIREN_GAP    = 3'd5;

  localparam tmr_t RST_EXIT_DELAY   = 16'd10000;
  localparam tmr_t RST_KEY_TIMEOUT  = 16'd3000;
  localparam tmr_t RST_BLINK_HALF   = 16'd300;
  localparam tmr_t RST_SIREN_PERIOD = 16'd1600;
  localparam tmr_t RST_SIREN_BEEP   = 16'd300;
  localparam tmr_t RST_SIREN_GAP    = 16'd200;

  // Bits of the notice-sent flag register.
  localparam int FLG_DISARMED = 0;
  localparam int FLG_ARMED    = 1;
  localparam int FLG_ALARM    = 2;
  localparam int FLG_RESTORED = 3;

  typedef struct packed {
    tmr_t exit_delay;
    tmr_t key_timeout;
    tmr_t blink_half;
    tmr_t siren_period;
    tmr_t siren_beep;
    tmr_t siren_gap;
  } kiac_cfg_t;

  typedef struct packed {
    mode_t      mode;
    logic [2:0] prev_buttons;
    logic [3:0] key_buf;
    logic [1:0] key_count;
    tmr_t       key_gap;
    tmr_t       exit_count;
    tmr_t       blink_count;
    logic       blink_level;
    tmr_t       siren_phase;
    logic       siren_running;
    logic       buzzer;
    logic [3:0] flags;
  } kiac_state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       red_led;
    logic       green_led;
    logic       buzzer;
    logic       notice_disarmed;
    logic       notice_armed;
    logic       notice_alarm;
    logic       notice_restored;
  } kiac_result_t;

endpackage

### hdl/kiac_step.sv
`timescale 1ns / 1ps

// Next-state and result logic for one millisecond tick.
module kiac_step (
  input  kiac_pkg::kiac_state_t  state,
  input  kiac_pkg::kiac_cfg_t    cfg,
  input  logic [2:0]             buttons,
  input  logic                   motion,
  input  logic [1:0]             remote,
  output kiac_pkg::kiac_state_t  state_nxt,
  output kiac_pkg::kiac_result_t result
);
  import kiac_pkg::*;

  function automatic tmr_t sat_inc(tmr_t v);
    return (v == '1) ? v : tmr_t'(v + 1'b1);
  endfunction

  function automatic kiac_state_t buzzer_off(kiac_state_t s);
    s.siren_running = 1'b0;
    s.siren_phase   = '0;
    s.buzzer        = 1'b0;
    return s;
  endfunction

  function automatic kiac_state_t enter_mode(kiac_state_t s, mode_t m);
    s.mode = m;
    case (m)
      MODE_DISARMED: begin
        s       = buzzer_off(s);
        s.flags = '0;
      end
      MODE_EXIT: begin
        s                  = buzzer_off(s);
        s.exit_count       = '0;
        s.blink_count      = '0;
        s.blink_level      = 1'b1;
        s.flags[FLG_ARMED] = 1'b0;
      end
      MODE_ARMED: begin
        s                     = buzzer_off(s);
        s.flags[FLG_ALARM]    = 1'b0;
        s.flags[FLG_RESTORED] = 1'b0;
        s.flags[FLG_DISARMED] = 1'b0;
      end
      MODE_ALARM: begin
      end
      default: begin
      end
    endcase
    return s;
  endfunction

  // One key press; a finished three-key sequence is matched and cleared.
  function automatic kiac_state_t press(kiac_state_t s, logic [1:0] key, tmr_t timeout);
    if (s.key_count != 2'd0 && s.key_gap > timeout) begin
      s.key_count = 2'd0;
    end
    if (s.key_count == 2'd0) begin
      s.key_buf = {2'b00, key};
    end else if (s.key_count == 2'd1) begin
      s.key_buf = {key, s.key_buf[1:0]};
    end
    s.key_count = s.key_count + 2'd1;
    s.key_gap   = '0;
    if (s.key_count == 2'(SEQ_LEN)) begin
      if (s.key_buf[1:0] == KEY_ONE && s.key_buf[3:2] == KEY_TWO && key == KEY_THREE &&
          s.mode == MODE_DISARMED) begin
        s = enter_mode(s, MODE_EXIT);
      end
      if (s.key_buf[1:0] == KEY_THREE && s.key_buf[3:2] == KEY_TWO && key == KEY_ONE) begin
        s = enter_mode(s, MODE_DISARMED);
      end
      s.key_count = 2'd0;
    end
    return s;
  endfunction

  logic [TIMER_BITS:0]   beep_gap;
  logic [TIMER_BITS+1:0] beep2_gap;

  assign beep_gap  = {1'b0, cfg.siren_beep} + {1'b0, cfg.siren_gap};
  assign beep2_gap = {1'b0, beep_gap} + {2'b00, cfg.siren_beep};

  always_comb begin
    kiac_state_t s;
    logic        nd, na, nal, nr;
    s   = state;
    nd  = 1'b0;
    na  = 1'b0;
    nal = 1'b0;
    nr  = 1'b0;

    if (s.key_count != 2'd0) begin
      s.key_gap = sat_inc(s.key_gap);
    end
    if (s.mode == MODE_EXIT) begin
      s.exit_count  = sat_inc(s.exit_count);
      s.blink_count = sat_inc(s.blink_count);
    end

    // falling edges, in button order
    for (int k = 0; k < 3; k++) begin
      if (state.prev_buttons[k] && !buttons[k]) begin
        s = press(s, 2'(k + 1), cfg.key_timeout);
      end
    end
    s.prev_buttons = buttons;

    if (remote == REMOTE_ARM) begin
      if (s.mode == MODE_DISARMED) begin
        s = enter_mode(s, MODE_EXIT);
      end
    end else if (remote == REMOTE_DISARM) begin
      s = enter_mode(s, MODE_DISARMED);
    end

    if (s.mode == MODE_DISARMED && !s.flags[FLG_DISARMED]) begin
      nd                    = 1'b1;
      s.flags[FLG_DISARMED] = 1'b1;
    end

    if (s.mode == MODE_EXIT) begin
      if (s.blink_count >= cfg.blink_half) begin
        s.blink_count = '0;
        s.blink_level = ~s.blink_level;
      end
      if (s.exit_count >= cfg.exit_delay) begin
        s = enter_mode(s, MODE_ARMED);
      end
    end

    if (s.mode == MODE_ARMED && !s.flags[FLG_ARMED]) begin
      na                 = 1'b1;
      s.flags[FLG_ARMED] = 1'b1;
    end

    if (s.mode == MODE_ARMED && motion) begin
      s = enter_mode(s, MODE_ALARM);
    end

    if (s.mode == MODE_ALARM) begin
      if (motion) begin
        if (!s.siren_running) begin
          s.siren_running = 1'b1;
          s.siren_phase   = '0;
        end else begin
          s.siren_phase = sat_inc(s.siren_phase);
        end
        if (s.siren_phase >= cfg.siren_period) begin
          s.siren_phase = '0;
        end
        s.buzzer = (s.siren_phase < cfg.siren_beep) ||
                   ({1'b0, s.siren_phase} >= beep_gap &&
                    {2'b00, s.siren_phase} < beep2_gap);
        if (!s.flags[FLG_ALARM]) begin
          nal                   = 1'b1;
          s.flags[FLG_ALARM]    = 1'b1;
          s.flags[FLG_RESTORED] = 1'b0;
        end
      end else begin
        s = buzzer_off(s);
        if (!s.flags[FLG_RESTORED]) begin
          nr                    = 1'b1;
          s.flags[FLG_RESTORED] = 1'b1;
        end
        s = enter_mode(s, MODE_ARMED);
      end
    end

    state_nxt = s;

    case (s.mode)
      MODE_DISARMED: result.mode = MODE_CODE_DISARMED;
      MODE_EXIT:     result.mode = MODE_CODE_EXIT;
      MODE_ARMED:    result.mode = MODE_CODE_ARMED;
      MODE_ALARM:    result.mode = MODE_CODE_ALARM;
      default:       result.mode = MODE_CODE_DISARMED;
    endcase
    result.red_led         = (s.mode == MODE_EXIT) ? s.blink_level :
                             (s.mode == MODE_ARMED || s.mode == MODE_ALARM);
    result.green_led       = (s.mode == MODE_DISARMED);
    result.buzzer          = s.buzzer;
    result.notice_disarmed = nd;
    result.notice_armed    = na;
    result.notice_alarm    = nal;
    result.notice_restored = nr;
  end

endmodule

### hdl/keypad_intruder_alarm_controller_core.sv
`timescale 1ns / 1ps

// Keypad intruder alarm controller. Each input transaction is one millisecond
// tick carrying the three active-low button levels, the motion level and an
// authenticated remote command; each tick produces exactly one result
// transaction with the mode, LED and buzzer drive and one-shot notice flags.
// Key sequence 1-2-3 arms through an exit countdown, 3-2-1 disarms; motion
// while armed raises an alarm with a two-beep siren. Throughput is one tick
// per clock while in_stall is low: the whole tick update is a single pass of
// logic from the state registers to the next state and a result register.
// A two-entry result buffer (output register plus skid register, the skid
// entry filled while the output holds a result not taken) lets a new tick
// be accepted while a result waits; in_stall rises only when both are full.
// Configuration registers (index 0..5: exit delay, key timeout, blink half
// period, siren period, beep length, beep gap) are always ready and should
// be written only while no tick is in flight; other indexes are ignored.
module keypad_intruder_alarm_controller_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // tick input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_button_one_level,
  input  logic                           in_button_two_level,
  input  logic                           in_button_three_level,
  input  logic                           in_motion_level,
  input  logic [1:0]                     in_remote_command,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_mode,
  output logic                           out_red_led,
  output logic                           out_green_led,
  output logic                           out_buzzer,
  output logic                           out_notice_disarmed,
  output logic                           out_notice_armed,
  output logic                           out_notice_alarm,
  output logic                           out_notice_restored,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kiac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kiac_pkg::TIMER_BITS-1:0] cfg_data
);
  import kiac_pkg::*;

  kiac_cfg_t    cfg_r;
  kiac_state_t  state_r;
  kiac_state_t  state_nxt;
  kiac_result_t result;

  // result buffer
  kiac_result_t out_r;
  kiac_result_t skid_r;
  logic         out_valid_r;
  logic         skid_valid_r;

  logic in_acc;
  logic out_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;

  kiac_step u_step (
    .state     (state_r),
    .cfg       (cfg_r),
    .buttons   ({in_button_three_level, in_button_two_level, in_button_one_level}),
    .motion    (in_motion_level),
    .remote    (in_remote_command),
    .state_nxt (state_nxt),
    .result    (result)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.exit_delay   <= RST_EXIT_DELAY;
      cfg_r.key_timeout  <= RST_KEY_TIMEOUT;
      cfg_r.blink_half   <= RST_BLINK_HALF;
      cfg_r.siren_period <= RST_SIREN_PERIOD;
      cfg_r.siren_beep   <= RST_SIREN_BEEP;
      cfg_r.siren_gap    <= RST_SIREN_GAP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EXIT_DELAY:   cfg_r.exit_delay   <= cfg_data;
        CFG_KEY_TIMEOUT:  cfg_r.key_timeout  <= cfg_data;
        CFG_BLINK_HALF:   cfg_r.blink_half   <= cfg_data;
        CFG_SIREN_PERIOD: cfg_r.siren_period <= cfg_data;
        CFG_SIREN_BEEP:   cfg_r.siren_beep   <= cfg_data;
        CFG_SIREN_GAP:    cfg_r.siren_gap    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Controller state advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode          <= MODE_DISARMED;
      state_r.prev_buttons  <= 3'b111;
      state_r.key_buf       <= '0;
      state_r.key_count     <= '0;
      state_r.key_gap       <= '0;
      state_r.exit_count    <= '0;
      state_r.blink_count   <= '0;
      state_r.blink_level   <= 1'b0;
      state_r.siren_phase   <= '0;
      state_r.siren_running <= 1'b0;
      state_r.buzzer        <= 1'b0;
      state_r.flags         <= '0;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // Result buffer control: the skid entry fills only when the output
  // register holds a result that is not taken this cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_take) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_acc;
        end
      end else if (in_acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_acc) begin
        out_r <= result;
      end
    end else if (in_acc) begin
      skid_r <= result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_mode            = out_r.mode;
  assign out_red_led         = out_r.red_led;
  assign out_green_led       = out_r.green_led;
  assign out_buzzer          = out_r.buzzer;
  assign out_notice_disarmed = out_r.notice_disarmed;
  assign out_notice_armed    = out_r.notice_armed;
  assign out_notice_alarm    = out_r.notice_alarm;
  assign out_notice_restored = out_r.notice_restored;

endmodule
